[hw/rtl/srpd_pkg.sv]
// Shared types and constants for the sensor reply packet deframer.
`timescale 1ns / 1ps

package srpd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 247;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 1'd1;

  localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd2000;

  localparam logic [15:0] HDR_SYNC = 16'hEF01;
  localparam logic [7:0]  HDR_FLAG = 8'h07;

  typedef enum logic [1:0] {
    KIND_CONFIRM  = 2'd0,
    KIND_PARAM    = 2'd1,
    KIND_CHECKSUM = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_PACKET     = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_tick;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    kind_t      kind;
    logic       last;
    status_t    status;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

endpackage

[hw/rtl/srpd_core.sv]
// Header hunt, length capture, payload tagging and tick timeout.
`timescale 1ns / 1ps

module srpd_core #(
  parameter int unsigned MAX_PAYLOAD = srpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [srpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             accept,
  input  srpd_pkg::in_word_t               in_word,
  output srpd_pkg::result_t                result
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  logic [31:0] device_address_r;
  logic [15:0] timeout_ticks_r;

  phase_t      phase_r, phase_nxt;
  logic [47:0] window_r, window_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic [15:0] ticks_inc;
  logic [15:0] length;

  assign ticks_inc = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
  assign length    = {len_hi_r, in_word.rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= srpd_pkg::DEVICE_ADDRESS_RST;
      timeout_ticks_r  <= srpd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srpd_pkg::CFG_DEVICE_ADDRESS: device_address_r <= cfg_wdata[31:0];
        srpd_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    ticks_nxt  = ticks_r;
    result     = '0;

    if (accept) begin
      if (in_word.is_tick) begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= timeout_ticks_r) begin
          ticks_nxt          = '0;
          result.valid       = 1'b1;
          result.word.last   = 1'b1;
          result.word.status = srpd_pkg::ST_TIMEOUT;
        end
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            // The window is emptied on a match so header bytes never count twice.
            if (window_r == {srpd_pkg::HDR_SYNC, device_address_r} &&
                in_word.rx_byte == srpd_pkg::HDR_FLAG) begin
              window_nxt = '0;
              phase_nxt  = PH_LEN_HI;
            end else begin
              window_nxt = {window_r[39:0], in_word.rx_byte};
            end
          end
          PH_LEN_HI: begin
            len_hi_nxt = in_word.rx_byte;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (length == 16'd0 || length > 16'(MAX_PAYLOAD)) begin
              phase_nxt          = PH_HUNT;
              result.valid       = 1'b1;
              result.word.last   = 1'b1;
              result.word.status = srpd_pkg::ST_BAD_LENGTH;
            end else begin
              left_nxt  = length[7:0];
              pos_nxt   = '0;
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            result.valid          = 1'b1;
            result.word.data_byte = in_word.rx_byte;
            result.word.byte_index = pos_r;
            result.word.status    = srpd_pkg::ST_PACKET;
            result.word.last      = (left_r <= 8'd1);
            if (pos_r == 8'd0) begin
              result.word.kind = srpd_pkg::KIND_CONFIRM;
            end else if (left_r <= 8'd2) begin
              result.word.kind = srpd_pkg::KIND_CHECKSUM;
            end else begin
              result.word.kind = srpd_pkg::KIND_PARAM;
            end
            pos_nxt = pos_r + 8'd1;
            if (left_r <= 8'd1) begin
              left_nxt  = '0;
              phase_nxt = PH_HUNT;
              ticks_nxt = '0;
            end else begin
              left_nxt = left_r - 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= '0;
      len_hi_r <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      ticks_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule

[hw/rtl/srpd_outbuf.sv]
// Result register with a skid stage so input stays open while a result waits.
`timescale 1ns / 1ps

module srpd_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srpd_pkg::result_t     result,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srpd_pkg::out_word_t   out_data
);

  logic                main_valid_r;
  srpd_pkg::out_word_t main_word_r;
  logic                skid_valid_r;
  srpd_pkg::out_word_t skid_word_r;

  logic drain;

  // A new result can only arrive while the skid stage is empty.
  assign in_ready  = !skid_valid_r;
  assign drain     = !main_valid_r || out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      main_valid_r <= skid_valid_r || result.valid;
      skid_valid_r <= 1'b0;
    end else if (result.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      main_word_r <= skid_valid_r ? skid_word_r : result.word;
    end else if (result.valid) begin
      skid_word_r <= result.word;
    end
  end

endmodule

[hw/rtl/sensor_reply_packet_deframer.sv]
// Result words are registered to out_data; the skid stage holds one while out_ready stalls.
// Throughput: one input word per cycle; the skid stage keeps in_ready high while one
// result waits, so input stalls only when two results are held back by out_ready.
// Reset is synchronous and active low: hunting restarts with an empty window, tick count
// zero, device_address all ones and timeout_ticks 2000; no result words are held.
`timescale 1ns / 1ps

module sensor_reply_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = srpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [srpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  srpd_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srpd_pkg::out_word_t              out_data
);

  srpd_pkg::result_t result;
  logic              accept;

  assign accept = in_valid && in_ready;

  srpd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_word  (in_data),
    .result   (result)
  );

  srpd_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTH
  // A full skid stage means the result register is holding a word too.
  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("skid stage full with empty result register");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != srpd_pkg::ST_PACKET |-> out_data.last)
    else $error("status word without last");

  a_checksum_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == srpd_pkg::KIND_CHECKSUM |-> out_data.byte_index != 8'd0)
    else $error("checksum word at index zero");

  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && result.valid && !$past(out_valid && !out_ready) |=> out_valid)
    else $error("result word lost after acceptance");
`endif

endmodule
